FILE: rtl/mcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcd_pkg;

	localparam int TICK_W   = 16;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SCAN_W   = 2;
	localparam int DIGITS   = 4;
	localparam int SEG_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [MINUTE_W-1:0] MINUTES_PER_HOUR = 6'd60;
	localparam logic [HOUR_W-1:0]   HOURS_PER_DAY    = 5'd24;
	localparam logic [HOUR_W-1:0]   HOURS_PER_HALF   = 5'd12;
	localparam logic [SEG_W-1:0]    DP_BIT           = 8'h80;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MINUTE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_HOUR         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_SPAN_MINUTES = 2'd2;

	localparam logic [TICK_W-1:0]   TICKS_PER_MINUTE_RST = 16'd10;
	localparam logic [HOUR_W-1:0]   ALARM_HOUR_RST       = 5'd8;
	localparam logic [MINUTE_W-1:0] ALARM_SPAN_RST       = 6'd2;

	// scan positions
	localparam logic [SCAN_W-1:0] SCAN_MIN_UNITS  = 2'd0;
	localparam logic [SCAN_W-1:0] SCAN_MIN_TENS   = 2'd1;
	localparam logic [SCAN_W-1:0] SCAN_HOUR_UNITS = 2'd2;
	localparam logic [SCAN_W-1:0] SCAN_HOUR_TENS  = 2'd3;

	typedef struct packed {
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic                fmt_24;
	} clock_state_t;

	// a-g in bits 0-6, common cathode
	function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		begin
			case (d)
				4'd0: s = 8'b0011_1111;
				4'd1: s = 8'b0000_0110;
				4'd2: s = 8'b0101_1011;
				4'd3: s = 8'b0100_1111;
				4'd4: s = 8'b0110_0110;
				4'd5: s = 8'b0110_1101;
				4'd6: s = 8'b0111_1101;
				4'd7: s = 8'b0000_0111;
				4'd8: s = 8'b0111_1111;
				4'd9: s = 8'b0110_1111;
				default: s = 8'h00;
			endcase
			seg_of = s;
		end
	endfunction

	// tens digit of a value below 64: (v * 13) >> 7 is exact there
	function automatic logic [3:0] tens_of(input logic [MINUTE_W-1:0] v);
		logic [MINUTE_W+3:0] p;
		begin
			p = {4'd0, v} * 10'd13;
			tens_of = {1'b0, p[MINUTE_W+3:7]};
		end
	endfunction

endpackage

`default_nettype wire

FILE: rtl/mcd_digit.sv
`timescale 1ns / 1ps
`default_nettype none

module mcd_digit
	import mcd_pkg::*;
(
	input  wire clock_state_t     st,
	input  wire [SCAN_W-1:0]      scan,
	output logic [DIGITS-1:0]     digit_enable,
	output logic [SEG_W-1:0]      segments
);

	logic [HOUR_W-1:0]   hour_mod;
	logic [HOUR_W-1:0]   hour_shown;
	logic [3:0]          min_tens;
	logic [3:0]          min_units;
	logic [3:0]          hour_tens;
	logic [3:0]          hour_units;
	logic [MINUTE_W-1:0] min_tens_x10;
	logic [MINUTE_W-1:0] hour_tens_x10;
	logic [3:0]          digit;
	logic                dp_on;

	always_comb begin
		hour_mod = (st.hour >= HOURS_PER_HALF) ? st.hour - HOURS_PER_HALF : st.hour;
		if (st.fmt_24) begin
			hour_shown = st.hour;
		end else if (hour_mod == '0) begin
			hour_shown = HOURS_PER_HALF;
		end else begin
			hour_shown = hour_mod;
		end
	end

	always_comb begin
		min_tens      = tens_of(st.minute);
		min_tens_x10  = MINUTE_W'({min_tens, 3'b000} + {2'b00, min_tens, 1'b0});
		min_units     = 4'(st.minute - min_tens_x10);
		hour_tens     = tens_of({1'b0, hour_shown});
		hour_tens_x10 = MINUTE_W'({hour_tens, 3'b000} + {2'b00, hour_tens, 1'b0});
		hour_units    = 4'({1'b0, hour_shown} - hour_tens_x10);
	end

	always_comb begin
		case (scan)
			SCAN_MIN_UNITS:  digit = min_units;
			SCAN_MIN_TENS:   digit = min_tens;
			SCAN_HOUR_UNITS: digit = hour_units;
			SCAN_HOUR_TENS:  digit = hour_tens;
			default:         digit = min_units;
		endcase
		// point marks PM, on the minute units digit only
		dp_on = (scan == SCAN_MIN_UNITS) && !st.fmt_24 && (st.hour >= HOURS_PER_HALF);
		segments     = seg_of(digit) | (dp_on ? DP_BIT : '0);
		digit_enable = DIGITS'(1) << scan;
	end

endmodule

`default_nettype wire

FILE: rtl/multiplexed_clock_display.sv
`timescale 1ns / 1ps
`default_nettype none

// Four-digit multiplexed clock display. Each accepted word on the input channel
// is one refresh tick carrying the sampled button level; it yields one result
// word with the digit select and segments of the scan position held before the
// tick, plus the time, display mode and alarm LED after it. The counters and the
// segment decode settle in one pass into the output register, and a new tick is
// taken every cycle while the output register is empty or being drained.
// Configuration writes land at once.

module multiplexed_clock_display
	import mcd_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire                   button_level,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic [DIGITS-1:0]     digit_enable,
	output logic [SEG_W-1:0]      segments,
	output logic                  alarm_led,
	output logic [HOUR_W-1:0]     hours_now,
	output logic [MINUTE_W-1:0]   minutes_now,
	output logic                  mode_now,
	input  wire                   cfg_we,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data
);

	logic [TICK_W-1:0]   ticks_per_minute_q;
	logic [HOUR_W-1:0]   alarm_hour_q;
	logic [MINUTE_W-1:0] alarm_span_q;

	clock_state_t        st_q;
	clock_state_t        st_next;
	logic [SCAN_W-1:0]   scan_q;
	logic [TICK_W-1:0]   tick_q;
	logic [TICK_W-1:0]   tick_inc;
	logic [TICK_W-1:0]   tick_next;
	logic                last_button_q;

	logic                out_valid_q;
	logic [DIGITS-1:0]   digit_enable_q;
	logic [SEG_W-1:0]    segments_q;
	logic                alarm_led_q;
	logic [HOUR_W-1:0]   hours_q;
	logic [MINUTE_W-1:0] minutes_q;
	logic                mode_q;

	logic [DIGITS-1:0]   dig_en;
	logic [SEG_W-1:0]    dig_seg;
	logic                alarm_next;
	logic                in_fire;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_minute_q <= TICKS_PER_MINUTE_RST;
			alarm_hour_q       <= ALARM_HOUR_RST;
			alarm_span_q       <= ALARM_SPAN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICKS_PER_MINUTE:   ticks_per_minute_q <= cfg_data;
				REG_ALARM_HOUR:         alarm_hour_q <= cfg_data[HOUR_W-1:0];
				REG_ALARM_SPAN_MINUTES: alarm_span_q <= cfg_data[MINUTE_W-1:0];
				default: ;
			endcase
		end
	end

	mcd_digit u_digit (
		.st           (st_q),
		.scan         (scan_q),
		.digit_enable (dig_en),
		.segments     (dig_seg)
	);

	always_comb begin
		st_next  = st_q;
		tick_inc = tick_q + TICK_W'(1);
		tick_next = tick_inc;
		// advance one minute when the divider reaches its limit
		if (tick_inc >= ticks_per_minute_q) begin
			tick_next = '0;
			if (st_q.minute >= MINUTES_PER_HOUR - MINUTE_W'(1)) begin
				st_next.minute = '0;
				st_next.hour   = (st_q.hour >= HOURS_PER_DAY - HOUR_W'(1)) ?
				                 '0 : st_q.hour + HOUR_W'(1);
			end else begin
				st_next.minute = st_q.minute + MINUTE_W'(1);
			end
		end
		if (last_button_q && !button_level) begin
			st_next.fmt_24 = !st_q.fmt_24;
		end
		alarm_next = (st_next.hour == alarm_hour_q) && (st_next.minute < alarm_span_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= '0;
			scan_q        <= SCAN_MIN_UNITS;
			tick_q        <= '0;
			last_button_q <= 1'b1;
		end else if (in_fire) begin
			st_q          <= st_next;
			scan_q        <= scan_q + SCAN_W'(1);
			tick_q        <= tick_next;
			last_button_q <= button_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// result word; hold while stalled
	always_ff @(posedge clk) begin
		if (in_fire) begin
			digit_enable_q <= dig_en;
			segments_q     <= dig_seg;
			alarm_led_q    <= alarm_next;
			hours_q        <= st_next.hour;
			minutes_q      <= st_next.minute;
			mode_q         <= st_next.fmt_24;
		end
	end

	assign out_valid    = out_valid_q;
	assign digit_enable = digit_enable_q;
	assign segments     = segments_q;
	assign alarm_led    = alarm_led_q;
	assign hours_now    = hours_q;
	assign minutes_now  = minutes_q;
	assign mode_now     = mode_q;

	a_minute_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.minute < MINUTES_PER_HOUR)
		else $error("minute count out of range");

	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.hour < HOURS_PER_DAY)
		else $error("hour count out of range");

	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> scan_q == $past(scan_q) + SCAN_W'(1))
		else $error("scan did not advance on accepted word");

	a_out_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot(digit_enable_q))
		else $error("digit select not one-hot");

	a_out_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> hours_q == st_q.hour && minutes_q == st_q.minute
		            && mode_q == st_q.fmt_24)
		else $error("result time differs from clock state");

endmodule

`default_nettype wire

FILE: sim/display_checker.sv
`timescale 1ns / 1ps

module display_checker
	import mcd_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire                  in_ready,
	input  wire                  button_level,
	input  wire                  out_valid,
	input  wire                  out_ready,
	input  wire [DIGITS-1:0]     digit_enable,
	input  wire [SEG_W-1:0]      segments,
	input  wire                  alarm_led,
	input  wire [HOUR_W-1:0]     hours_now,
	input  wire [MINUTE_W-1:0]   minutes_now,
	input  wire                  mode_now,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data,
	output int                   mismatches,
	output int                   waiting
);

	typedef struct packed {
		logic [DIGITS-1:0]   enable;
		logic [SEG_W-1:0]    seg;
		logic                alarm;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic                mode;
	} display_word_t;

	logic [TICK_W-1:0]   ticks_per_min;
	logic [HOUR_W-1:0]   alarm_hr;
	logic [MINUTE_W-1:0] alarm_span;

	logic [HOUR_W-1:0]   hour;
	logic [MINUTE_W-1:0] minute;
	logic                mode_24;
	logic [SCAN_W-1:0]   scan_pos;
	logic [TICK_W-1:0]   divider;
	logic                prev_level;

	display_word_t expected_words[$];

	// drive the digit from the held time, then advance the clock and the mode
	function automatic display_word_t advance_tick(input logic level);
		display_word_t w;
		logic [HOUR_W-1:0] shown;
		logic [3:0] d;
		logic [TICK_W-1:0] next_div;
		begin
			if (mode_24)
				shown = hour;
			else if (hour % 12 == 0)
				shown = 5'd12;
			else
				shown = HOUR_W'(hour % 12);
			case (scan_pos)
				SCAN_MIN_UNITS:  d = 4'(minute % 10);
				SCAN_MIN_TENS:   d = 4'(minute / 10);
				SCAN_HOUR_UNITS: d = 4'(shown % 10);
				default:         d = 4'(shown / 10);
			endcase
			case (d)
				4'd0: w.seg = 8'h3F;
				4'd1: w.seg = 8'h06;
				4'd2: w.seg = 8'h5B;
				4'd3: w.seg = 8'h4F;
				4'd4: w.seg = 8'h66;
				4'd5: w.seg = 8'h6D;
				4'd6: w.seg = 8'h7D;
				4'd7: w.seg = 8'h07;
				4'd8: w.seg = 8'h7F;
				4'd9: w.seg = 8'h6F;
				default: w.seg = 8'h00;
			endcase
			// PM point on the minute units digit only
			if (scan_pos == SCAN_MIN_UNITS && !mode_24 && hour >= HOURS_PER_HALF)
				w.seg = w.seg | DP_BIT;
			w.enable = 4'b0001 << scan_pos;
			scan_pos = scan_pos + 1'b1;

			next_div = divider + 1'b1;
			if (next_div >= ticks_per_min) begin
				divider = '0;
				if (minute == MINUTES_PER_HOUR - 1) begin
					minute = '0;
					hour = (hour == HOURS_PER_DAY - 1) ? '0 : hour + 1'b1;
				end else begin
					minute = minute + 1'b1;
				end
			end else begin
				divider = next_div;
			end
			w.alarm = (hour == alarm_hr) && (minute < alarm_span);

			if (prev_level && !level)
				mode_24 = !mode_24;
			prev_level = level;

			w.hour = hour;
			w.minute = minute;
			w.mode = mode_24;
			return w;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : check
		display_word_t got;
		display_word_t want;
		if (!arst_n) begin
			ticks_per_min = TICKS_PER_MINUTE_RST;
			alarm_hr = ALARM_HOUR_RST;
			alarm_span = ALARM_SPAN_RST;
			hour = '0;
			minute = '0;
			mode_24 = 1'b0;
			scan_pos = SCAN_MIN_UNITS;
			divider = '0;
			prev_level = 1'b1;
			expected_words.delete();
			mismatches = 0;
			waiting = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {digit_enable, segments, alarm_led, hours_now, minutes_now, mode_now};
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: word with none expected: en=%h seg=%h", $realtime,
							digit_enable, segments);
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: mismatch exp en=%h seg=%h alarm=%b hr=%0d min=%0d",
								" mode=%b / got en=%h seg=%h alarm=%b hr=%0d min=%0d mode=%b"},
								$realtime, want.enable, want.seg, want.alarm, want.hour,
								want.minute, want.mode, got.enable, got.seg, got.alarm,
								got.hour, got.minute, got.mode);
					end
				end
			end
			if (in_valid && in_ready)
				expected_words.push_back(advance_tick(button_level));
			if (cfg_we) begin
				case (cfg_index)
					REG_TICKS_PER_MINUTE:   ticks_per_min = cfg_data[TICK_W-1:0];
					REG_ALARM_HOUR:         alarm_hr = cfg_data[HOUR_W-1:0];
					REG_ALARM_SPAN_MINUTES: alarm_span = cfg_data[MINUTE_W-1:0];
					default: ;
				endcase
			end
			waiting = expected_words.size();
		end
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench
	import mcd_pkg::*;
();

	localparam int HOLD_CYCLES = 50;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASES      = 14;
	localparam int PHASE_TICKS = 84;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic button_level = 1'b1;
	logic out_ready = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	wire                in_ready;
	wire                out_valid;
	wire [DIGITS-1:0]   digit_enable;
	wire [SEG_W-1:0]    segments;
	wire                alarm_led;
	wire [HOUR_W-1:0]   hours_now;
	wire [MINUTE_W-1:0] minutes_now;
	wire                mode_now;

	int word_errors;
	int words_waiting;
	int send_idle = 0;
	int recv_stall = 0;
	int ticks_sent = 0;
	int words_seen = 0;
	int quiet = 0;
	int hold_left = 0;
	int hold_asks = 0;
	int holds_begun = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	multiplexed_clock_display dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.button_level(button_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digit_enable(digit_enable),
		.segments(segments),
		.alarm_led(alarm_led),
		.hours_now(hours_now),
		.minutes_now(minutes_now),
		.mode_now(mode_now),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	display_checker watch (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.button_level(button_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digit_enable(digit_enable),
		.segments(segments),
		.alarm_led(alarm_led),
		.hours_now(hours_now),
		.minutes_now(minutes_now),
		.mode_now(mode_now),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(word_errors),
		.waiting(words_waiting)
	);

	// receiver: random stalls, or a long hold when asked
	always @(negedge clk) begin
		if (holds_begun != hold_asks) begin
			holds_begun = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet = 0;
		else
			quiet++;
		if (out_valid && out_ready)
			words_seen++;
		if (quiet >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_tick(input logic level);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		button_level <= level;
		do @(posedge clk); while (!in_ready);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// hold the sender until every word is back
	task automatic drain();
		in_valid <= 1'b0;
		while (words_seen != ticks_sent)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	initial begin : stimulus
		logic [5:0] press_a;
		logic [19:0] press_b;
		logic level;
		logic [TICK_W-1:0] tpm;
		logic [HOUR_W-1:0] ah;
		logic [MINUTE_W-1:0] span;
		press_a = 6'b101001;
		press_b = 20'hA5C36;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: 12 shown for hour 0, mode toggles on presses
		for (int i = 0; i < 6; i++)
			send_tick(press_a[i]);
		drain();

		// spare index must not disturb anything; advance every tick, alarm all hour
		reg_write(REG_SPARE, 16'hFFFF);
		reg_write(REG_TICKS_PER_MINUTE, 16'd0);
		reg_write(REG_ALARM_HOUR, 16'd0);
		reg_write(REG_ALARM_SPAN_MINUTES, 16'd60);
		for (int i = 0; i < 20; i++)
			send_tick(press_b[i]);
		drain();

		level = 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 87; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 87; end
				default: begin send_idle = 20; recv_stall = 20; end
			endcase
			// a huge divider, then a lowered one that it already exceeds
			if (p == 4)
				tpm = 16'hFFFF;
			else if (p == 5)
				tpm = TICK_W'($urandom_range(2, 12));
			else
				tpm = TICK_W'(p % 2);
			if (p % 5 == 3)
				ah = HOUR_W'($urandom_range(24, 31));
			else
				ah = HOUR_W'((hours_now + $urandom_range(0, 1)) % 24);
			case (p % 5)
				0: span = 6'd60;
				1: span = 6'd0;
				2: span = MINUTE_W'($urandom_range(1, 59));
				3: span = MINUTE_W'($urandom_range(0, 63));
				default: span = 6'd63;
			endcase
			reg_write(REG_TICKS_PER_MINUTE, tpm);
			reg_write(REG_ALARM_HOUR, CFG_DATA_W'(($urandom << HOUR_W) | ah));
			reg_write(REG_ALARM_SPAN_MINUTES, CFG_DATA_W'(($urandom << MINUTE_W) | span));
			if (p % 3 == 1)
				reg_write(REG_SPARE, CFG_DATA_W'($urandom));
			if (p % 8 == 0)
				hold_asks++;
			for (int n = 0; n < PHASE_TICKS; n++) begin
				if ($urandom_range(0, 99) < 15)
					level = !level;
				send_tick(level);
			end
			drain();
		end

		repeat (5) @(negedge clk);
		if (word_errors == 0 && words_waiting == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
